@@ hdl/prf_pkg.sv @@
// Shared types and constants for the page replacement block.
`default_nettype none
package prf_pkg;

    localparam int FRAMES    = 16;
    localparam int PAGE_BITS = 16;
    localparam int SLOT_W    = 4;
    localparam int RANK_W    = 4;
    localparam int COUNT_W   = 5;
    localparam int CNT_W     = 32;
    localparam int ADDR_W    = 3;
    localparam int DATA_W    = 32;
    localparam int LEAVES    = 1 << $clog2(FRAMES);

    localparam logic [RANK_W-1:0]  RANK_MAX = RANK_W'(FRAMES - 1);
    localparam logic [COUNT_W-1:0] COUNT_MAX = COUNT_W'(FRAMES);
    localparam logic [CNT_W-1:0]   CNT_SAT = '1;

    localparam logic REG_POLICY = 1'b0;
    localparam logic REG_FRAMES = 1'b1;

    localparam logic POLICY_FIFO = 1'b0;
    localparam logic POLICY_LRU  = 1'b1;

    localparam logic [COUNT_W-1:0] FRAMES_RESET = COUNT_W'(16);

    typedef struct packed {
        logic capture;
        logic decide;
        logic commit;
    } prf_cmd_t;

    typedef struct packed {
        logic out_stall;
    } prf_status_t;

endpackage
`default_nettype wire

@@ hdl/page_replacement_fifo_lru.sv @@
// Top level of the FIFO / LRU page replacement frame table.
//
//   Channel   Direction  Handshake         Payload
//   s_        in         s_valid/s_ready   s_page_number
//   m_        out        m_valid/m_ready   m_hit, m_frame_slot, m_evicted_valid,
//                                          m_evicted_page, m_hit_total, m_fault_total
//   APB       in         psel/penable      policy_mode (0x0), frames_in_use (0x4)
//
// Each transaction has a lookup step for the parallel tag compare and victim
// search over all active frames, then an update step for table, ranks and counters.
// A new transaction is taken in the commit cycle, so no input is taken during the lookup of the one in flight.
// A stalled result holds the commit and input until m_ready frees the result register.
// Reset is synchronous: all frames empty, ranks, pointer and counts zero.
`default_nettype none
module page_replacement_fifo_lru (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [prf_pkg::ADDR_W-1:0]      paddr,
    input  logic [prf_pkg::DATA_W-1:0]      pwdata,
    output logic [prf_pkg::DATA_W-1:0]      prdata,
    output logic                            pready,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [prf_pkg::PAGE_BITS-1:0]   s_page_number,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic                            m_hit,
    output logic [prf_pkg::SLOT_W-1:0]      m_frame_slot,
    output logic                            m_evicted_valid,
    output logic [prf_pkg::PAGE_BITS-1:0]   m_evicted_page,
    output logic [prf_pkg::CNT_W-1:0]       m_hit_total,
    output logic [prf_pkg::CNT_W-1:0]       m_fault_total
);

    logic                        policy_mode;
    logic [prf_pkg::COUNT_W-1:0] frames_in_use;
    prf_pkg::prf_cmd_t           cmd;
    prf_pkg::prf_status_t        status;

    prf_regs u_regs (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .policy_mode   (policy_mode),
        .frames_in_use (frames_in_use)
    );

    prf_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    prf_datapath u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .status          (status),
        .policy_mode     (policy_mode),
        .frames_in_use   (frames_in_use),
        .s_page_number   (s_page_number),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_hit           (m_hit),
        .m_frame_slot    (m_frame_slot),
        .m_evicted_valid (m_evicted_valid),
        .m_evicted_page  (m_evicted_page),
        .m_hit_total     (m_hit_total),
        .m_fault_total   (m_fault_total)
    );

    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken while a transaction is in lookup");

    a_hit_no_evict: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_hit && m_evicted_valid))
        else $error("hit reported with an eviction");

    a_evict_page_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_evicted_valid |-> m_evicted_page == '0)
        else $error("evicted page nonzero without eviction");

    a_hit_counted: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_hit |-> m_hit_total != '0)
        else $error("hit result with zero hit count");

    a_fault_counted: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_hit |-> m_fault_total != '0)
        else $error("fault result with zero fault count");

endmodule
`default_nettype wire

@@ hdl/prf_regs.sv @@
// APB configuration registers: replacement policy and active frame count.
`default_nettype none
module prf_regs (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [prf_pkg::ADDR_W-1:0]    paddr,
    input  logic [prf_pkg::DATA_W-1:0]    pwdata,
    output logic [prf_pkg::DATA_W-1:0]    prdata,
    output logic                          pready,
    output logic                          policy_mode,
    output logic [prf_pkg::COUNT_W-1:0]   frames_in_use
);

    logic                        policy_reg;
    logic [prf_pkg::COUNT_W-1:0] frames_reg;
    logic                        wr_en;
    logic                        reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_sel = paddr[2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            policy_reg <= prf_pkg::POLICY_FIFO;
            frames_reg <= prf_pkg::FRAMES_RESET;
        end else if (wr_en) begin
            case (reg_sel)
                prf_pkg::REG_POLICY: policy_reg <= pwdata[0];
                prf_pkg::REG_FRAMES: frames_reg <= pwdata[prf_pkg::COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_sel)
            prf_pkg::REG_POLICY: prdata = {{(prf_pkg::DATA_W-1){1'b0}}, policy_reg};
            prf_pkg::REG_FRAMES:
                prdata = {{(prf_pkg::DATA_W-prf_pkg::COUNT_W){1'b0}}, frames_reg};
            default: prdata = '0;
        endcase
    end

    assign policy_mode   = policy_reg;
    assign frames_in_use = frames_reg;

endmodule
`default_nettype wire

@@ hdl/prf_ctrl.sv @@
// Controller state machine: capture, lookup, commit sequencing.
`default_nettype none
module prf_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  prf_pkg::prf_status_t  status,
    output prf_pkg::prf_cmd_t     cmd
);

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_LOOKUP = 3'b010,
        ST_UPDATE = 3'b100
    } state_t;

    state_t state_reg, state_next;
    logic   accept;

    always_comb begin
        s_ready = 1'b0;
        case (state_reg)
            ST_IDLE:   s_ready = 1'b1;
            ST_UPDATE: s_ready = !status.out_stall;
            default:   s_ready = 1'b0;
        endcase
    end

    assign accept = s_valid && s_ready;

    always_comb begin
        state_next  = state_reg;
        cmd.capture = accept;
        cmd.decide  = 1'b0;
        cmd.commit  = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (accept) state_next = ST_LOOKUP;
            end
            ST_LOOKUP: begin
                cmd.decide = 1'b1;
                state_next = ST_UPDATE;
            end
            ST_UPDATE: begin
                if (!status.out_stall) begin
                    cmd.commit = 1'b1;
                    state_next = accept ? ST_LOOKUP : ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule
`default_nettype wire

@@ hdl/prf_datapath.sv @@
// Datapath: frame table, parallel lookup, victim choice, recency ranks, counters.
`default_nettype none
module prf_datapath (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  prf_pkg::prf_cmd_t               cmd,
    output prf_pkg::prf_status_t            status,
    input  logic                            policy_mode,
    input  logic [prf_pkg::COUNT_W-1:0]     frames_in_use,
    input  logic [prf_pkg::PAGE_BITS-1:0]   s_page_number,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic                            m_hit,
    output logic [prf_pkg::SLOT_W-1:0]      m_frame_slot,
    output logic                            m_evicted_valid,
    output logic [prf_pkg::PAGE_BITS-1:0]   m_evicted_page,
    output logic [prf_pkg::CNT_W-1:0]       m_hit_total,
    output logic [prf_pkg::CNT_W-1:0]       m_fault_total
);

    localparam int N  = prf_pkg::FRAMES;
    localparam int NL = prf_pkg::LEAVES;

    logic [prf_pkg::PAGE_BITS-1:0] page_reg;
    logic [prf_pkg::PAGE_BITS-1:0] frame_page_reg [N];
    logic [N-1:0]                  frame_valid_reg;
    logic [prf_pkg::RANK_W-1:0]    rank_reg [N];
    logic [prf_pkg::SLOT_W-1:0]    fifo_ptr_reg;
    logic [prf_pkg::CNT_W-1:0]     hit_cnt_reg;
    logic [prf_pkg::CNT_W-1:0]     fault_cnt_reg;

    logic                          dec_hit_reg;
    logic                          dec_fill_reg;
    logic                          dec_evict_reg;
    logic                          dec_fifo_adv_reg;
    logic [prf_pkg::SLOT_W-1:0]    dec_slot_reg;
    logic [prf_pkg::SLOT_W-1:0]    dec_fifo_next_reg;

    logic                          out_valid_reg;
    logic                          out_hit_reg;
    logic [prf_pkg::SLOT_W-1:0]    out_slot_reg;
    logic                          out_evict_reg;
    logic [prf_pkg::PAGE_BITS-1:0] out_evict_page_reg;

    logic [prf_pkg::COUNT_W-1:0]   count_eff;
    logic [N-1:0]                  active;
    logic                          hit_found;
    logic [prf_pkg::SLOT_W-1:0]    hit_idx;
    logic                          empty_found;
    logic [prf_pkg::SLOT_W-1:0]    empty_idx;
    logic [prf_pkg::SLOT_W-1:0]    fifo_slot;
    logic [prf_pkg::SLOT_W-1:0]    fifo_next;
    logic [prf_pkg::SLOT_W-1:0]    lru_idx;
    logic [prf_pkg::SLOT_W-1:0]    victim_idx;

    logic                          node_act  [2*NL];
    logic [prf_pkg::RANK_W-1:0]    node_rank [2*NL];
    logic [prf_pkg::SLOT_W-1:0]    node_idx  [2*NL];

    logic                          touch_en;
    logic [prf_pkg::RANK_W-1:0]    old_rank;

    // clamp the active frame count
    always_comb begin
        if (frames_in_use == '0) begin
            count_eff = prf_pkg::COUNT_W'(1);
        end else if (frames_in_use > prf_pkg::COUNT_MAX) begin
            count_eff = prf_pkg::COUNT_MAX;
        end else begin
            count_eff = frames_in_use;
        end
    end

    always_comb begin
        for (int i = 0; i < N; i++) begin
            active[i] = prf_pkg::COUNT_W'(i) < count_eff;
        end
    end

    // lowest matching frame and lowest empty frame
    always_comb begin
        hit_found   = 1'b0;
        hit_idx     = '0;
        empty_found = 1'b0;
        empty_idx   = '0;
        for (int i = N - 1; i >= 0; i--) begin
            if (active[i] && frame_valid_reg[i] && frame_page_reg[i] == page_reg) begin
                hit_found = 1'b1;
                hit_idx   = prf_pkg::SLOT_W'(i);
            end
            if (active[i] && !frame_valid_reg[i]) begin
                empty_found = 1'b1;
                empty_idx   = prf_pkg::SLOT_W'(i);
            end
        end
    end

    // round-robin victim
    always_comb begin
        fifo_slot = ({1'b0, fifo_ptr_reg} < count_eff) ? fifo_ptr_reg : '0;
        fifo_next = (({1'b0, fifo_slot} + prf_pkg::COUNT_W'(1)) < count_eff)
                    ? fifo_slot + prf_pkg::SLOT_W'(1) : '0;
    end

    // oldest active frame, ties to the lower index
    always_comb begin
        for (int i = 0; i < NL; i++) begin
            if (i < N) begin
                node_act[NL+i]  = active[i];
                node_rank[NL+i] = rank_reg[i];
            end else begin
                node_act[NL+i]  = 1'b0;
                node_rank[NL+i] = '0;
            end
            node_idx[NL+i] = prf_pkg::SLOT_W'(i);
        end
        node_act[0]  = 1'b0;
        node_rank[0] = '0;
        node_idx[0]  = '0;
        for (int j = NL - 1; j >= 1; j--) begin
            if (!node_act[2*j+1] ||
                (node_act[2*j] && node_rank[2*j] >= node_rank[2*j+1])) begin
                node_act[j]  = node_act[2*j];
                node_rank[j] = node_rank[2*j];
                node_idx[j]  = node_idx[2*j];
            end else begin
                node_act[j]  = node_act[2*j+1];
                node_rank[j] = node_rank[2*j+1];
                node_idx[j]  = node_idx[2*j+1];
            end
        end
        lru_idx = (NL > 1) ? node_idx[1] : '0;
    end

    assign victim_idx = (policy_mode == prf_pkg::POLICY_LRU) ? lru_idx : fifo_slot;

    always_ff @(posedge aclk) begin
        if (cmd.capture) page_reg <= s_page_number;
        if (cmd.decide) begin
            dec_hit_reg       <= hit_found;
            dec_fill_reg      <= !hit_found && empty_found;
            dec_evict_reg     <= !hit_found && !empty_found;
            dec_fifo_adv_reg  <= !hit_found && !empty_found &&
                                 policy_mode == prf_pkg::POLICY_FIFO;
            dec_fifo_next_reg <= fifo_next;
            if (hit_found) begin
                dec_slot_reg <= hit_idx;
            end else if (empty_found) begin
                dec_slot_reg <= empty_idx;
            end else begin
                dec_slot_reg <= victim_idx;
            end
        end
    end

    assign touch_en = !(dec_hit_reg && policy_mode == prf_pkg::POLICY_FIFO);
    assign old_rank = rank_reg[dec_slot_reg];

    // table, ranks and counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_valid_reg <= '0;
            fifo_ptr_reg    <= '0;
            hit_cnt_reg     <= '0;
            fault_cnt_reg   <= '0;
            for (int i = 0; i < N; i++) rank_reg[i] <= '0;
        end else if (cmd.commit) begin
            if (!dec_hit_reg) begin
                frame_page_reg[dec_slot_reg]  <= page_reg;
                frame_valid_reg[dec_slot_reg] <= 1'b1;
                if (fault_cnt_reg != prf_pkg::CNT_SAT) fault_cnt_reg <= fault_cnt_reg + 1'b1;
            end else if (hit_cnt_reg != prf_pkg::CNT_SAT) begin
                hit_cnt_reg <= hit_cnt_reg + 1'b1;
            end
            if (dec_fifo_adv_reg) fifo_ptr_reg <= dec_fifo_next_reg;
            if (touch_en) begin
                for (int i = 0; i < N; i++) begin
                    if (prf_pkg::SLOT_W'(i) == dec_slot_reg) begin
                        rank_reg[i] <= '0;
                    end else if ((dec_fill_reg || rank_reg[i] < old_rank) &&
                                 rank_reg[i] < prf_pkg::RANK_MAX) begin
                        rank_reg[i] <= rank_reg[i] + 1'b1;
                    end
                end
            end
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.commit) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            out_hit_reg        <= dec_hit_reg;
            out_slot_reg       <= dec_slot_reg;
            out_evict_reg      <= dec_evict_reg;
            out_evict_page_reg <= dec_evict_reg ? frame_page_reg[dec_slot_reg] : '0;
        end
    end

    assign status.out_stall = out_valid_reg && !m_ready;

    assign m_valid         = out_valid_reg;
    assign m_hit           = out_hit_reg;
    assign m_frame_slot    = out_slot_reg;
    assign m_evicted_valid = out_evict_reg;
    assign m_evicted_page  = out_evict_page_reg;
    assign m_hit_total     = hit_cnt_reg;
    assign m_fault_total   = fault_cnt_reg;

endmodule
`default_nettype wire

@@ test/page_replacement_fifo_lru_tb.sv @@
// Self-checking testbench for the FIFO / LRU page replacement frame table.
`timescale 1ns / 1ps
module page_replacement_fifo_lru_tb;

    typedef struct packed {
        logic                          hit;
        logic [prf_pkg::SLOT_W-1:0]    frame_slot;
        logic                          evicted_valid;
        logic [prf_pkg::PAGE_BITS-1:0] evicted_page;
        logic [prf_pkg::CNT_W-1:0]     hit_total;
        logic [prf_pkg::CNT_W-1:0]     fault_total;
    } page_lookup_t;

    typedef struct packed {
        logic                          is_cfg;
        logic                          cfg_reg;
        logic [prf_pkg::COUNT_W-1:0]   cfg_val;
        logic [prf_pkg::PAGE_BITS-1:0] page;
        logic                          typed;
        page_lookup_t                  want;
    } ref_step_t;

    localparam int DIRECTED_ROWS = 29;
    localparam int RANDOM_PHASES = 10;
    localparam int PHASE_REFS    = 140;
    localparam int HOLD_PHASE    = 4;
    localparam int PAUSE_PHASE   = 6;
    localparam int LONG_HOLD     = 150;
    localparam int SETTLE_CYCLES = 4;
    localparam int DRAIN_CYCLES  = 10;
    localparam int QUIET_LIMIT   = 2000;
    localparam int POOL_SIZE     = 20;

    logic                          aclk = 1'b0;
    logic                          aresetn = 1'b0;
    logic                          psel = 1'b0;
    logic                          penable = 1'b0;
    logic                          pwrite = 1'b0;
    logic [prf_pkg::ADDR_W-1:0]    paddr = '0;
    logic [prf_pkg::DATA_W-1:0]    pwdata = '0;
    logic [prf_pkg::DATA_W-1:0]    prdata;
    logic                          pready;
    logic                          s_valid = 1'b0;
    logic                          s_ready;
    logic [prf_pkg::PAGE_BITS-1:0] s_page_number = '0;
    logic                          m_valid;
    logic                          m_ready = 1'b0;
    logic                          m_hit;
    logic [prf_pkg::SLOT_W-1:0]    m_frame_slot;
    logic                          m_evicted_valid;
    logic [prf_pkg::PAGE_BITS-1:0] m_evicted_page;
    logic [prf_pkg::CNT_W-1:0]     m_hit_total;
    logic [prf_pkg::CNT_W-1:0]     m_fault_total;

    page_replacement_fifo_lru dut (
        .aclk(aclk), .aresetn(aresetn),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .s_valid(s_valid), .s_ready(s_ready), .s_page_number(s_page_number),
        .m_valid(m_valid), .m_ready(m_ready), .m_hit(m_hit),
        .m_frame_slot(m_frame_slot), .m_evicted_valid(m_evicted_valid),
        .m_evicted_page(m_evicted_page), .m_hit_total(m_hit_total),
        .m_fault_total(m_fault_total)
    );

    always #5 aclk = ~aclk;

    // frame table mirror
    logic [prf_pkg::PAGE_BITS-1:0] page_tag [prf_pkg::FRAMES] = '{default: '0};
    logic                          resident [prf_pkg::FRAMES] = '{default: 1'b0};
    logic [prf_pkg::RANK_W-1:0]    age      [prf_pkg::FRAMES] = '{default: '0};
    int                            fifo_next = 0;
    logic [prf_pkg::CNT_W-1:0]     hit_tally = '0;
    logic [prf_pkg::CNT_W-1:0]     fault_tally = '0;
    logic                          policy_sel = prf_pkg::POLICY_FIFO;
    logic [prf_pkg::COUNT_W-1:0]   frame_limit_raw = prf_pkg::FRAMES_RESET;

    page_lookup_t pending_lookups [$];
    int  errors = 0;
    int  refs_sent = 0;
    int  hits_seen = 0;
    int  evictions_seen = 0;
    int  settings_written = 0;
    int  quiet_cycles = 0;
    int  stall_left = 0;
    int  hold_count = 0;
    logic idling = 1'b0;
    logic long_hold_go = 1'b0;

    ref_step_t directed_steps [DIRECTED_ROWS] = '{
        '{1'b0, prf_pkg::REG_POLICY, 5'd0, 16'h0000, 1'b1,
          '{1'b0, 4'd0, 1'b0, 16'h0000, 32'd0, 32'd1}},
        '{1'b0, prf_pkg::REG_POLICY, 5'd0, 16'h0000, 1'b1,
          '{1'b1, 4'd0, 1'b0, 16'h0000, 32'd1, 32'd1}},
        '{1'b0, prf_pkg::REG_POLICY, 5'd0, 16'hFFFF, 1'b1,
          '{1'b0, 4'd1, 1'b0, 16'h0000, 32'd1, 32'd2}},
        '{1'b0, prf_pkg::REG_POLICY, 5'd0, 16'hFFFF, 1'b1,
          '{1'b1, 4'd1, 1'b0, 16'h0000, 32'd2, 32'd2}},
        '{1'b1, prf_pkg::REG_FRAMES, 5'd2, 16'h0000, 1'b0, '0},
        '{1'b0, prf_pkg::REG_POLICY, 5'd0, 16'h5555, 1'b1,
          '{1'b0, 4'd0, 1'b1, 16'h0000, 32'd2, 32'd3}},
        '{1'b0, prf_pkg::REG_POLICY, 5'd0, 16'hAAAA, 1'b1,
          '{1'b0, 4'd1, 1'b1, 16'hFFFF, 32'd2, 32'd4}},
        '{1'b0, prf_pkg::REG_POLICY, 5'd0, 16'h0000, 1'b0, '0},
        '{1'b1, prf_pkg::REG_POLICY, 5'(prf_pkg::POLICY_LRU), 16'h0000, 1'b0, '0},
        '{1'b0, prf_pkg::REG_POLICY, 5'd0, 16'hAAAA, 1'b0, '0},
        '{1'b0, prf_pkg::REG_POLICY, 5'd0, 16'h1234, 1'b0, '0},
        '{1'b0, prf_pkg::REG_POLICY, 5'd0, 16'h0000, 1'b0, '0},
        '{1'b1, prf_pkg::REG_FRAMES, 5'd0, 16'h0000, 1'b0, '0},
        '{1'b0, prf_pkg::REG_POLICY, 5'd0, 16'h0000, 1'b0, '0},
        '{1'b0, prf_pkg::REG_POLICY, 5'd0, 16'h0000, 1'b0, '0},
        '{1'b1, prf_pkg::REG_FRAMES, 5'd31, 16'h0000, 1'b0, '0},
        '{1'b0, prf_pkg::REG_POLICY, 5'd0, 16'h0000, 1'b0, '0},
        '{1'b1, prf_pkg::REG_POLICY, 5'(prf_pkg::POLICY_FIFO), 16'h0000, 1'b0, '0},
        '{1'b1, prf_pkg::REG_FRAMES, 5'd1, 16'h0000, 1'b0, '0},
        '{1'b0, prf_pkg::REG_POLICY, 5'd0, 16'h4321, 1'b0, '0},
        '{1'b1, prf_pkg::REG_FRAMES, 5'd16, 16'h0000, 1'b0, '0},
        '{1'b0, prf_pkg::REG_POLICY, 5'd0, 16'h8000, 1'b0, '0},
        '{1'b0, prf_pkg::REG_POLICY, 5'd0, 16'h0001, 1'b0, '0},
        '{1'b0, prf_pkg::REG_POLICY, 5'd0, 16'h7FFF, 1'b0, '0},
        '{1'b0, prf_pkg::REG_POLICY, 5'd0, 16'hFFFF, 1'b0, '0},
        '{1'b0, prf_pkg::REG_POLICY, 5'd0, 16'h0001, 1'b0, '0},
        '{1'b1, prf_pkg::REG_POLICY, 5'(prf_pkg::POLICY_LRU), 16'h0000, 1'b0, '0},
        '{1'b0, prf_pkg::REG_POLICY, 5'd0, 16'h8000, 1'b0, '0},
        '{1'b0, prf_pkg::REG_POLICY, 5'd0, 16'hFFFE, 1'b0, '0}
    };

    function automatic int active_frames();
        if (frame_limit_raw == 0)
            return 1;
        if (frame_limit_raw > prf_pkg::FRAMES)
            return prf_pkg::FRAMES;
        return int'(frame_limit_raw);
    endfunction

    task automatic promote(input int slot, input bit was_empty);
        logic [prf_pkg::RANK_W-1:0] old;
        old = age[slot];
        for (int i = 0; i < prf_pkg::FRAMES; i++) begin
            if (i != slot && (was_empty || age[i] < old) && age[i] < prf_pkg::RANK_MAX)
                age[i] = age[i] + 1'b1;
        end
        age[slot] = '0;
    endtask

    task automatic predict_lookup(input logic [prf_pkg::PAGE_BITS-1:0] page,
                                  output page_lookup_t res);
        int active;
        int slot;
        bit found;
        bit empty_found;
        logic [prf_pkg::RANK_W-1:0] best;
        res = '0;
        active = active_frames();
        slot = 0;
        found = 1'b0;
        empty_found = 1'b0;
        for (int i = 0; i < active; i++) begin
            if (!found && resident[i] && page_tag[i] == page) begin
                slot = i;
                found = 1'b1;
            end
        end
        if (found) begin
            res.hit = 1'b1;
            if (hit_tally != prf_pkg::CNT_SAT)
                hit_tally = hit_tally + 1'b1;
            if (policy_sel == prf_pkg::POLICY_LRU)
                promote(slot, 1'b0);
        end else begin
            if (fault_tally != prf_pkg::CNT_SAT)
                fault_tally = fault_tally + 1'b1;
            for (int i = 0; i < active; i++) begin
                if (!empty_found && !resident[i]) begin
                    slot = i;
                    empty_found = 1'b1;
                end
            end
            if (empty_found) begin
                resident[slot] = 1'b1;
                page_tag[slot] = page;
                promote(slot, 1'b1);
            end else begin
                if (policy_sel == prf_pkg::POLICY_LRU) begin
                    best = age[0];
                    slot = 0;
                    for (int i = 1; i < active; i++) begin
                        if (age[i] > best) begin
                            best = age[i];
                            slot = i;
                        end
                    end
                end else begin
                    slot = (fifo_next < active) ? fifo_next : 0;
                    fifo_next = (slot + 1 < active) ? slot + 1 : 0;
                end
                res.evicted_valid = 1'b1;
                res.evicted_page = page_tag[slot];
                page_tag[slot] = page;
                promote(slot, 1'b0);
            end
        end
        res.frame_slot = prf_pkg::SLOT_W'(slot);
        res.hit_total = hit_tally;
        res.fault_total = fault_tally;
    endtask

    task automatic send_page(input logic [prf_pkg::PAGE_BITS-1:0] page, input bit typed,
                             input page_lookup_t want);
        page_lookup_t predicted;
        int gap;
        s_valid <= 1'b1;
        s_page_number <= page;
        do @(posedge aclk); while (!s_ready);
        predict_lookup(page, predicted);
        pending_lookups.push_back(typed ? want : predicted);
        refs_sent++;
        gap = (idling && $urandom_range(0, 4) == 0) ? $urandom_range(1, 6) : 0;
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic settle();
        s_valid <= 1'b0;
        while (pending_lookups.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic apb_write(input logic reg_idx, input logic [prf_pkg::DATA_W-1:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {reg_idx, 2'b00};
        pwdata <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        if (reg_idx == prf_pkg::REG_POLICY)
            policy_sel = value[0];
        else
            frame_limit_raw = value[prf_pkg::COUNT_W-1:0];
        settings_written++;
        @(posedge aclk);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            errors++;
            $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
        end
    endtask

    always @(posedge aclk) begin : drain_results
        page_lookup_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_lookups.size() == 0) begin
                errors++;
                $display("%0t: result transaction with no reference outstanding", $time);
            end else begin
                want = pending_lookups.pop_front();
                check_field("hit", 32'(want.hit), 32'(m_hit));
                check_field("frame_slot", 32'(want.frame_slot), 32'(m_frame_slot));
                check_field("evicted_valid", 32'(want.evicted_valid), 32'(m_evicted_valid));
                check_field("evicted_page", 32'(want.evicted_page), 32'(m_evicted_page));
                check_field("hit_total", want.hit_total, m_hit_total);
                check_field("fault_total", want.fault_total, m_fault_total);
                if (m_hit)
                    hits_seen++;
                if (m_evicted_valid)
                    evictions_seen++;
            end
        end
        if (long_hold_go && hold_count < LONG_HOLD) begin
            m_ready <= 1'b0;
            hold_count++;
        end else if (stall_left != 0) begin
            m_ready <= 1'b0;
            stall_left--;
        end else if (idling && $urandom_range(0, 5) == 0) begin
            m_ready <= 1'b0;
            stall_left = $urandom_range(0, 5);
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || (psel && penable))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        while (quiet_cycles < QUIET_LIMIT)
            @(posedge aclk);
        $display("%0t: no transaction for %0d cycles, %0d results outstanding",
                 $time, QUIET_LIMIT, pending_lookups.size());
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        logic [prf_pkg::PAGE_BITS-1:0] pool [POOL_SIZE];
        logic [prf_pkg::PAGE_BITS-1:0] page;
        int span;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        idling <= 1'b1;

        foreach (directed_steps[k]) begin
            if (directed_steps[k].is_cfg) begin
                settle();
                apb_write(directed_steps[k].cfg_reg,
                          prf_pkg::DATA_W'(directed_steps[k].cfg_val));
            end else begin
                send_page(directed_steps[k].page, directed_steps[k].typed,
                          directed_steps[k].want);
            end
        end

        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            settle();
            apb_write(prf_pkg::REG_POLICY,
                      ($urandom_range(0, 1) == 1) ? prf_pkg::DATA_W'(prf_pkg::POLICY_LRU)
                                                  : prf_pkg::DATA_W'(prf_pkg::POLICY_FIFO));
            apb_write(prf_pkg::REG_FRAMES, prf_pkg::DATA_W'($urandom_range(0, 31)));
            idling <= (phase != RANDOM_PHASES - 1) && (phase != HOLD_PHASE) && (phase % 3 != 2);
            if (phase == HOLD_PHASE)
                long_hold_go <= 1'b1;
            span = active_frames() + 4;
            for (int i = 0; i < POOL_SIZE; i++)
                pool[i] = prf_pkg::PAGE_BITS'($urandom);
            for (int n = 0; n < PHASE_REFS; n++) begin
                if (phase == PAUSE_PHASE && n == PHASE_REFS / 2)
                    settle();
                if ($urandom_range(0, 9) == 0)
                    page = prf_pkg::PAGE_BITS'($urandom);
                else
                    page = pool[$urandom_range(0, span - 1)];
                send_page(page, 1'b0, '0);
            end
        end

        s_valid <= 1'b0;
        while (pending_lookups.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("covered %0d page references over %0d register writes (FIFO and LRU,",
                 refs_sent, settings_written);
        $display("frame counts 0 to 31): %0d hits, %0d evictions, %0d mismatches",
                 hits_seen, evictions_seen, errors);
        if (errors == 0 && pending_lookups.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
